### rtl/core/kbs_pkg.sv
// Shared types and constants for the keyed byte scrambler.
package kbs_pkg;

   // Field and register widths.
   localparam int unsigned DATA_W  = 8;
   localparam int unsigned KEY_W   = 17;
   localparam int unsigned DIGIT_W = 4;
   localparam int unsigned CSR_IDX_W = 1;

   // Default number of key digits in use.
   localparam int unsigned KEY_DIGITS_DEFAULT = 5;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_VALUE       = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCRAMBLE_ENABLE = 1'd1;

   // Divide-by-ten by reciprocal multiplication, exact for any key word.
   localparam int unsigned DIV10_RECIP_W = 20;
   localparam logic [DIV10_RECIP_W-1:0] DIV10_RECIP = 20'hCCCCD;
   localparam int unsigned DIV10_SHIFT = 23;
   localparam int unsigned QUOT_W = 14;

   // Transform constants.
   localparam logic [DATA_W-1:0] ODD_MASK  = 8'h0A;
   localparam logic [DATA_W-1:0] EVEN_MASK = 8'h05;
   localparam logic [DATA_W-1:0] ODD_ADD   = 8'd2;
   localparam logic [DATA_W-1:0] EVEN_SUB  = 8'd3;

   // One item as it leaves the sequencing stage.
   typedef struct packed {
      logic [DATA_W-1:0]  data;
      logic               unscramble;
      logic               odd;
      logic               bypass;
      logic [DIGIT_W-1:0] offset;
   } stage_type;

endpackage

### rtl/core/keyed_byte_scrambler.sv
// Top level of the keyed byte scrambler.
//
// Items enter on the req_ channel (valid/ready) one byte each and leave on the
// rsp_ channel, one result item per input item, in order. Each byte passes an
// input stage that tracks frame position and key digit, then a result stage
// that applies the transform; both stages are registered, and one item can be
// accepted every cycle while the receiver keeps up and no digit sweep runs.
// A stalled receiver holds the result register; the input stage keeps one more
// item, after which req_ready drops until the receiver takes a result.
// Writing key_value starts a digit sweep, one divide-by-ten step per cycle for
// each key digit; req_ready is low during the sweep. Writes to scramble_enable
// are registered and need no sweep. Reset (synchronous, active high) empties
// both stages, clears the position and digit index, clears the key digits to
// zero and enables scrambling; no sweep is needed after reset.
module keyed_byte_scrambler #(
   parameter int unsigned KEY_DIGITS = kbs_pkg::KEY_DIGITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [kbs_pkg::DATA_W-1:0]     req_data_byte,
   input  logic                           req_unscramble,
   input  logic                           req_frame_start,
   input  logic                           req_pass_through,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [kbs_pkg::DATA_W-1:0]     rsp_result_byte,
   input  logic                           csr_wr_en,
   input  logic [kbs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kbs_pkg::KEY_W-1:0]      csr_wdata
);

   logic                                        enable_ff;
   logic                                        enable_in;
   logic                                        key_wr;
   logic                                        busy;
   logic [KEY_DIGITS-1:0][kbs_pkg::DIGIT_W-1:0] digits;
   logic                                        stage_valid;
   logic                                        stage_ready;
   kbs_pkg::stage_type                          stage;

   // Register decode.
   always_comb begin
      key_wr    = 1'b0;
      enable_in = enable_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            kbs_pkg::CSR_KEY_VALUE:       key_wr = 1'b1;
            kbs_pkg::CSR_SCRAMBLE_ENABLE: enable_in = csr_wdata[0];
            default:                      enable_in = enable_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else begin
         enable_ff <= enable_in;
      end
   end

   // Key digit sweep.
   kbs_digits #(.KEY_DIGITS(KEY_DIGITS)) u_digits (
      .clock     (clock),
      .reset     (reset),
      .key_wr    (key_wr),
      .key_value (csr_wdata),
      .busy      (busy),
      .digits    (digits)
   );

   // Input stage.
   kbs_seq #(.KEY_DIGITS(KEY_DIGITS)) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_unscramble   (req_unscramble),
      .req_frame_start  (req_frame_start),
      .req_pass_through (req_pass_through),
      .enable           (enable_ff),
      .busy             (busy),
      .digits           (digits),
      .stage_valid      (stage_valid),
      .stage_ready      (stage_ready),
      .stage            (stage)
   );

   // Result stage.
   kbs_xform u_xform (
      .clock           (clock),
      .reset           (reset),
      .stage_valid     (stage_valid),
      .stage_ready     (stage_ready),
      .stage           (stage),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_byte (rsp_result_byte)
   );

`ifndef ASSERT_OFF
   // No item is taken while the key digits are being recomputed.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_ready)
      else $error("item accepted during digit sweep");

   // A key write always starts a sweep.
   a_key_sweep: assert property (@(posedge clock) disable iff (reset)
      key_wr |=> busy)
      else $error("key write did not start digit sweep");

   // A held item in the input stage stays until the result stage takes it.
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      stage_valid && !stage_ready |=> stage_valid && $stable(stage))
      else $error("input stage item lost while stalled");
`endif

endmodule

### rtl/core/kbs_digits.sv
// Key digit extractor: splits the key word into decimal digits, one per cycle.
module kbs_digits #(
   parameter int unsigned KEY_DIGITS = kbs_pkg::KEY_DIGITS_DEFAULT,
   localparam int unsigned DIDX_W = (KEY_DIGITS > 1) ? $clog2(KEY_DIGITS) : 1
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          key_wr,
   input  logic [kbs_pkg::KEY_W-1:0]                     key_value,
   output logic                                          busy,
   output logic [KEY_DIGITS-1:0][kbs_pkg::DIGIT_W-1:0]   digits
);

   localparam int unsigned PROD_W = kbs_pkg::KEY_W + kbs_pkg::DIV10_RECIP_W;
   localparam logic [DIDX_W-1:0] LAST_IDX = DIDX_W'(KEY_DIGITS - 1);

   logic [kbs_pkg::KEY_W-1:0]                   work_ff;
   logic [kbs_pkg::KEY_W-1:0]                   work_in;
   logic [DIDX_W-1:0]                           cnt_ff;
   logic [DIDX_W-1:0]                           cnt_in;
   logic                                        busy_ff;
   logic                                        busy_in;
   logic [KEY_DIGITS-1:0][kbs_pkg::DIGIT_W-1:0] digits_ff;
   logic [KEY_DIGITS-1:0][kbs_pkg::DIGIT_W-1:0] digits_in;
   logic [PROD_W-1:0]                           prod;
   logic [kbs_pkg::QUOT_W-1:0]                  quot;
   logic [kbs_pkg::KEY_W-1:0]                   rem_full;

   // One division step: quotient by reciprocal, remainder by subtraction.
   assign prod = PROD_W'(work_ff) * PROD_W'(kbs_pkg::DIV10_RECIP);
   assign quot = prod[kbs_pkg::DIV10_SHIFT +: kbs_pkg::QUOT_W];
   assign rem_full = work_ff - (kbs_pkg::KEY_W'(quot) << 3) - (kbs_pkg::KEY_W'(quot) << 1);

   // Sweep control: a key write restarts the sweep at the lowest digit.
   always_comb begin
      work_in   = work_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      digits_in = digits_ff;
      if (key_wr) begin
         work_in = key_value;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         digits_in[cnt_ff] = rem_full[kbs_pkg::DIGIT_W-1:0];
         work_in = kbs_pkg::KEY_W'(quot);
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == LAST_IDX) begin
            busy_in = 1'b0;
            cnt_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         busy_ff   <= 1'b0;
         digits_ff <= '0;
      end else begin
         cnt_ff    <= cnt_in;
         busy_ff   <= busy_in;
         digits_ff <= digits_in;
      end
      work_ff <= work_in;
   end

   assign busy   = busy_ff;
   assign digits = digits_ff;

endmodule

### rtl/core/kbs_seq.sv
// Input stage: tracks frame position and key digit, registers each accepted item.
module kbs_seq #(
   parameter int unsigned KEY_DIGITS = kbs_pkg::KEY_DIGITS_DEFAULT,
   localparam int unsigned DIDX_W = (KEY_DIGITS > 1) ? $clog2(KEY_DIGITS) : 1
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   output logic                                          req_ready,
   input  logic [kbs_pkg::DATA_W-1:0]                    req_data_byte,
   input  logic                                          req_unscramble,
   input  logic                                          req_frame_start,
   input  logic                                          req_pass_through,
   input  logic                                          enable,
   input  logic                                          busy,
   input  logic [KEY_DIGITS-1:0][kbs_pkg::DIGIT_W-1:0]   digits,
   output logic                                          stage_valid,
   input  logic                                          stage_ready,
   output kbs_pkg::stage_type                            stage
);

   localparam logic [DIDX_W-1:0] LAST_IDX = DIDX_W'(KEY_DIGITS - 1);

   logic [DIDX_W-1:0]   didx_ff;
   logic [DIDX_W-1:0]   didx_in;
   logic                odd_ff;
   logic                odd_in;
   logic                valid_ff;
   logic                valid_in;
   kbs_pkg::stage_type  stage_ff;
   kbs_pkg::stage_type  stage_in;
   logic [DIDX_W-1:0]   cur_idx;
   logic                cur_odd;
   logic                accept;
   logic                bypass;

   // Take an item when the stage is free or drains this cycle and no sweep runs.
   assign req_ready = (!valid_ff || stage_ready) && !busy;
   assign accept    = req_valid && req_ready;

   // A frame start clears the position before the item is handled.
   assign cur_idx = req_frame_start ? '0 : didx_ff;
   assign cur_odd = req_frame_start ? 1'b0 : odd_ff;
   assign bypass  = req_pass_through || !enable;

   always_comb begin
      didx_in  = didx_ff;
      odd_in   = odd_ff;
      stage_in = stage_ff;
      valid_in = valid_ff && !stage_ready;
      if (accept) begin
         valid_in            = 1'b1;
         stage_in.data       = req_data_byte;
         stage_in.unscramble = req_unscramble;
         stage_in.odd        = cur_odd;
         stage_in.bypass     = bypass;
         stage_in.offset     = digits[cur_idx] + 1'b1;
         didx_in             = cur_idx;
         odd_in              = cur_odd;
         // Only transformed items advance the position.
         if (!bypass) begin
            didx_in = (cur_idx == LAST_IDX) ? '0 : cur_idx + 1'b1;
            odd_in  = !cur_odd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         didx_ff  <= '0;
         odd_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         didx_ff  <= didx_in;
         odd_ff   <= odd_in;
         valid_ff <= valid_in;
      end
      stage_ff <= stage_in;
   end

   assign stage_valid = valid_ff;
   assign stage       = stage_ff;

`ifndef ASSERT_OFF
   // The digit index never leaves the range of key digits.
   a_didx_range: assert property (@(posedge clock) disable iff (reset)
      didx_ff <= LAST_IDX)
      else $error("digit index out of range");

   // A frame start that is transformed leaves the position at the second byte.
   a_start_pos: assert property (@(posedge clock) disable iff (reset)
      accept && req_frame_start && !bypass |=> odd_ff)
      else $error("frame start did not restart the position");
`endif

endmodule

### rtl/core/kbs_xform.sv
// Output stage: applies the byte transform and holds the result item.
module kbs_xform (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        stage_valid,
   output logic                        stage_ready,
   input  kbs_pkg::stage_type          stage,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [kbs_pkg::DATA_W-1:0]  rsp_result_byte
);

   logic                        valid_ff;
   logic                        valid_in;
   logic [kbs_pkg::DATA_W-1:0]  result_ff;
   logic [kbs_pkg::DATA_W-1:0]  result_in;
   logic [kbs_pkg::DATA_W-1:0]  xformed;
   logic [kbs_pkg::DATA_W-1:0]  offset;

   assign offset = kbs_pkg::DATA_W'(stage.offset);

   // Byte transform for each position parity and direction.
   always_comb begin
      case ({stage.odd, stage.unscramble})
         2'b10:   xformed = ((stage.data + kbs_pkg::ODD_ADD) ^ kbs_pkg::ODD_MASK) + offset;
         2'b11:   xformed = ((stage.data - offset) ^ kbs_pkg::ODD_MASK) - kbs_pkg::ODD_ADD;
         2'b00:   xformed = ((stage.data - kbs_pkg::EVEN_SUB) ^ kbs_pkg::EVEN_MASK) - offset;
         default: xformed = ((stage.data + offset) ^ kbs_pkg::EVEN_MASK) + kbs_pkg::EVEN_SUB;
      endcase
   end

   // The result register frees up when empty or when the receiver takes it.
   assign stage_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in  = valid_ff && !rsp_ready;
      result_in = result_ff;
      if (stage_valid && stage_ready) begin
         valid_in  = 1'b1;
         result_in = stage.bypass ? stage.data : xformed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_byte = result_ff;

endmodule
